/* design/assert_macros.svh */
// Assertion macros used by the range table design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PRS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Expression must never be true outside reset.
`define PRS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

/* design/prs_pkg.sv */
// Shared types and constants of the port range set parser and matcher.
package prs_pkg;

	localparam int MAX_RANGES = 16;
	localparam int NCELL      = MAX_RANGES + 1;
	localparam int CNT_W      = $clog2(MAX_RANGES + 2);
	localparam int IDX_W      = $clog2(NCELL);
	localparam int TOTAL_W    = 5;
	localparam int COV_W      = 17;
	localparam int ACC_W      = 17;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);
	localparam logic [CNT_W-1:0] CELL_CNT = CNT_W'(NCELL);

	localparam logic [15:0]      VAL_MAX  = 16'hFFFF;
	localparam logic [ACC_W-1:0] ACC_SAT  = 17'h10000;
	localparam logic [7:0]       CH_DASH  = 8'h2D;
	localparam logic [7:0]       CH_COMMA = 8'h2C;
	localparam logic [7:0]       CH_ZERO  = 8'h30;
	localparam logic [7:0]       CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_CHAR   = 2'd1,
		OP_QUERY  = 2'd2,
		OP_STATUS = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_LOW   = 2'd1,
		PH_DASH  = 2'd2,
		PH_HIGH  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_REPORT
	} top_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_SCAN,
		T_BUILD
	} tbl_state_t;

	typedef struct packed {
		logic [15:0] lo;
		logic [15:0] hi;
	} rng_t;

	typedef struct packed {
		logic        start;
		logic        clr;
		logic [15:0] lo;
		logic [15:0] hi;
	} tbl_req_t;

	typedef struct packed {
		logic done;
		logic ok;
	} tbl_rsp_t;

endpackage

/* design/prs_cell.sv */
// One cell of the range chain: holds a range, shifts from its neighbour, tests a query.
module prs_cell (
	input  logic           clk,
	input  logic           shift_en,
	input  logic           load_en,
	input  prs_pkg::rng_t  shift_in,
	input  prs_pkg::rng_t  load_data,
	input  logic [15:0]    query,
	output prs_pkg::rng_t  data,
	output logic           hit
);

	prs_pkg::rng_t data_q;

	// Load wins over shift: the write lands after the chain has moved.
	always_ff @(posedge clk) begin
		if (load_en) begin
			data_q <= load_data;
		end else if (shift_en) begin
			data_q <= shift_in;
		end
	end

	assign data = data_q;
	assign hit  = (query >= data_q.lo) && (query <= data_q.hi);

endmodule

/* design/prs_table.sv */
// Sorted range table: a chain of cells with a merge-and-rebuild sequencer.
`include "assert_macros.svh"

module prs_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  prs_pkg::tbl_req_t            req,
	output prs_pkg::tbl_rsp_t            rsp,
	input  logic [15:0]                  query,
	output logic                         hit,
	output logic [prs_pkg::CNT_W-1:0]    count,
	output logic [prs_pkg::COV_W-1:0]    covered
);

	prs_pkg::tbl_state_t st_q, st_d;
	logic [prs_pkg::CNT_W-1:0] cnt_q, cnt_d, r_q, r_d, m_q, m_d, k_q, k_d;
	logic [prs_pkg::COV_W-1:0] cov_q, cov_d, acc_q, acc_d;
	logic [15:0] mlo_q, mlo_d, mhi_q, mhi_d;
	logic placed_q, placed_d, undo_q, undo_d;

	logic shift_en, wr_en;
	logic [prs_pkg::IDX_W-1:0] wr_idx;
	prs_pkg::rng_t wr_data, head, new_rng;
	prs_pkg::rng_t cell_data [prs_pkg::NCELL];
	logic [prs_pkg::NCELL-1:0] cell_hit;
	logic ovl;
	logic [prs_pkg::COV_W-1:0] head_len, new_len;

	for (genvar i = 0; i < prs_pkg::NCELL; i++) begin : g_cell
		prs_pkg::rng_t nb;
		if (i == prs_pkg::NCELL - 1) begin : g_last
			assign nb = cell_data[i];
		end else begin : g_mid
			assign nb = cell_data[i+1];
		end
		prs_cell u_cell (
			.clk       (clk),
			.shift_en  (shift_en),
			.load_en   (wr_en && (wr_idx == prs_pkg::IDX_W'(i))),
			.shift_in  (nb),
			.load_data (wr_data),
			.query     (query),
			.data      (cell_data[i]),
			.hit       (cell_hit[i])
		);
	end

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < prs_pkg::NCELL; i++) begin
			if (prs_pkg::CNT_W'(i) < cnt_q && cell_hit[i]) begin
				hit = 1'b1;
			end
		end
	end

	assign head    = cell_data[0];
	assign new_rng = '{lo: mlo_q, hi: mhi_q};
	// Overlapping or touching the range under construction
	assign ovl = ({1'b0, head.hi} + 17'd1 >= {1'b0, mlo_q}) &&
	             ({1'b0, head.lo} <= {1'b0, mhi_q} + 17'd1);
	assign head_len = {1'b0, head.hi} - {1'b0, head.lo} + 17'd1;
	assign new_len  = {1'b0, mhi_q} - {1'b0, mlo_q} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= prs_pkg::T_IDLE;
			cnt_q    <= '0;
			cov_q    <= '0;
			r_q      <= '0;
			m_q      <= '0;
			k_q      <= '0;
			acc_q    <= '0;
			placed_q <= 1'b0;
			undo_q   <= 1'b0;
		end else begin
			st_q     <= st_d;
			cnt_q    <= cnt_d;
			cov_q    <= cov_d;
			r_q      <= r_d;
			m_q      <= m_d;
			k_q      <= k_d;
			acc_q    <= acc_d;
			placed_q <= placed_d;
			undo_q   <= undo_d;
		end
	end

	always_ff @(posedge clk) begin
		mlo_q <= mlo_d;
		mhi_q <= mhi_d;
	end

	always_comb begin
		st_d     = st_q;
		cnt_d    = cnt_q;
		cov_d    = cov_q;
		r_d      = r_q;
		m_d      = m_q;
		k_d      = k_q;
		acc_d    = acc_q;
		placed_d = placed_q;
		undo_d   = undo_q;
		mlo_d    = mlo_q;
		mhi_d    = mhi_q;
		shift_en = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = '0;
		wr_data  = head;
		rsp      = '0;
		case (st_q)
			prs_pkg::T_IDLE: begin
				if (req.clr) begin
					cnt_d = '0;
					cov_d = '0;
				end else if (req.start) begin
					mlo_d    = req.lo;
					mhi_d    = req.hi;
					k_d      = '0;
					r_d      = cnt_q;
					m_d      = '0;
					acc_d    = '0;
					placed_d = 1'b0;
					undo_d   = 1'b0;
					st_d     = (cnt_q == '0) ? prs_pkg::T_BUILD : prs_pkg::T_SCAN;
				end
			end
			prs_pkg::T_SCAN: begin
				// Rotate the table once, widening the new range over its neighbours
				if (ovl) begin
					if (head.lo < mlo_q) mlo_d = head.lo;
					if (head.hi > mhi_q) mhi_d = head.hi;
				end
				shift_en = 1'b1;
				wr_en    = 1'b1;
				wr_idx   = prs_pkg::IDX_W'(cnt_q - 1'b1);
				k_d      = k_q + 1'b1;
				if (k_q == cnt_q - 1'b1) begin
					st_d = prs_pkg::T_BUILD;
				end
			end
			prs_pkg::T_BUILD: begin
				if (r_q != '0) begin
					if (ovl) begin
						// Absorbed into the merged range: drop
						shift_en = 1'b1;
						r_d      = r_q - 1'b1;
					end else if (!placed_q && head.lo > mhi_q) begin
						wr_en    = 1'b1;
						wr_idx   = prs_pkg::IDX_W'(r_q + m_q);
						wr_data  = new_rng;
						m_d      = m_q + 1'b1;
						placed_d = 1'b1;
						acc_d    = acc_q + new_len;
					end else begin
						shift_en = 1'b1;
						wr_en    = 1'b1;
						wr_idx   = prs_pkg::IDX_W'(r_q - 1'b1 + m_q);
						r_d      = r_q - 1'b1;
						m_d      = m_q + 1'b1;
						acc_d    = acc_q + head_len;
					end
				end else if (!placed_q) begin
					wr_en    = 1'b1;
					wr_idx   = prs_pkg::IDX_W'(m_q);
					wr_data  = new_rng;
					m_d      = m_q + 1'b1;
					placed_d = 1'b1;
					acc_d    = acc_q + new_len;
				end else if (!undo_q && m_q > prs_pkg::MAX_CNT) begin
					// Table full: run again and drop the new range
					r_d    = m_q;
					m_d    = '0;
					acc_d  = '0;
					undo_d = 1'b1;
				end else begin
					cnt_d    = m_q;
					cov_d    = acc_q;
					rsp.done = 1'b1;
					rsp.ok   = !undo_q;
					st_d     = prs_pkg::T_IDLE;
				end
			end
			default: begin
				st_d = prs_pkg::T_IDLE;
			end
		endcase
	end

	assign count   = cnt_q;
	assign covered = cov_q;

	`PRS_ASSERT(a_cnt_bound, clk, arst_n, st_q == prs_pkg::T_IDLE |-> cnt_q <= prs_pkg::MAX_CNT)
	`PRS_ASSERT(a_done_idle, clk, arst_n, rsp.done |=> st_q == prs_pkg::T_IDLE)
	`PRS_ASSERT(a_fill_bound, clk, arst_n, st_q == prs_pkg::T_BUILD |-> (r_q + m_q) <= prs_pkg::CELL_CNT)
	`PRS_NEVER(a_no_start_busy, clk, arst_n, req.start && st_q != prs_pkg::T_IDLE)

endmodule

/* design/port_range_set_parse_match.sv */
// Top level of the port range set: text parser, range table and result register.
// Clear, query, status and characters that finish no item go from idle through the report
// state into the result register. A character that finishes an item first waits in ST_WAIT
// while the table walks its cell chain, and walks it again when a full table is restored.
// One transaction in flight: s_tready is high only when idle with the result register empty.
// arst_n clears the parser, range and covered counts, stop/overflow flags and m_tvalid at once.
module port_range_set_parse_match (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // text_char[7:0], query_value[23:8]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // match_found[0], chars_consumed[16:1], parse_stopped[17],
	                               // range_total[22:18], covered_values[39:23],
	                               // table_overflow[40], zero fill [47:41]
);

	prs_pkg::top_state_t st_q, st_d;
	prs_pkg::phase_t     phase_q, phase_d;
	logic [prs_pkg::ACC_W-1:0] acc_q, acc_d;
	logic [15:0] pend_q, pend_d, seen_q, seen_d, mark_q, mark_d, pos_q, pos_d;
	logic halted_q, halted_d, ovf_q, ovf_d, comma_q, comma_d, match_q, match_d;
	logic        out_valid_q;
	logic [47:0] out_data_q;

	prs_pkg::tbl_req_t req;
	prs_pkg::tbl_rsp_t rsp;
	logic                         tbl_hit;
	logic [prs_pkg::CNT_W-1:0]    tbl_cnt;
	logic [prs_pkg::COV_W-1:0]    tbl_cov;

	prs_pkg::op_t op;
	logic [7:0]   ch;
	logic [15:0]  qv;
	logic         accept, is_digit;
	logic [3:0]   dval;
	logic [19:0]  acc_mul;
	logic [prs_pkg::ACC_W-1:0] acc_next;
	logic [16:0]  seen_inc, pos_inc;

	assign op       = prs_pkg::op_t'(s_tuser);
	assign ch       = s_tdata[7:0];
	assign qv       = s_tdata[23:8];
	// Hold off new work until the previous result has been taken
	assign s_tready = (st_q == prs_pkg::ST_IDLE) && !out_valid_q;
	assign accept   = s_tvalid && s_tready;

	assign is_digit = (ch >= prs_pkg::CH_ZERO) && (ch <= prs_pkg::CH_NINE);
	assign dval     = is_digit ? 4'(ch - prs_pkg::CH_ZERO) : 4'd0;
	// acc * 10 + digit, then saturate at one above the largest value
	assign acc_mul  = ({3'b0, acc_q} << 3) + ({3'b0, acc_q} << 1) + {16'b0, dval};
	assign acc_next = (acc_mul > {3'b0, prs_pkg::ACC_SAT}) ? prs_pkg::ACC_SAT
	                                                        : acc_mul[prs_pkg::ACC_W-1:0];
	assign seen_inc = {1'b0, seen_q} + 17'd1;
	assign pos_inc  = {1'b0, pos_q} + 17'd1;

	prs_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.query   (qv),
		.hit     (tbl_hit),
		.count   (tbl_cnt),
		.covered (tbl_cov)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= prs_pkg::ST_IDLE;
			phase_q  <= prs_pkg::PH_START;
			acc_q    <= '0;
			pend_q   <= '0;
			seen_q   <= '0;
			mark_q   <= '0;
			halted_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			st_q     <= st_d;
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			pend_q   <= pend_d;
			seen_q   <= seen_d;
			mark_q   <= mark_d;
			halted_q <= halted_d;
			ovf_q    <= ovf_d;
		end
	end

	// Per-transaction payload: position and terminator of the item under insertion, and query match
	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		comma_q <= comma_d;
		match_q <= match_d;
	end

	always_comb begin
		st_d     = st_q;
		phase_d  = phase_q;
		acc_d    = acc_q;
		pend_d   = pend_q;
		seen_d   = seen_q;
		mark_d   = mark_q;
		halted_d = halted_q;
		ovf_d    = ovf_q;
		pos_d    = pos_q;
		comma_d  = comma_q;
		match_d  = match_q;
		req      = '0;
		case (st_q)
			prs_pkg::ST_IDLE: begin
				if (accept) begin
					match_d = 1'b0;
					st_d    = prs_pkg::ST_REPORT;
					case (op)
						prs_pkg::OP_CLEAR: begin
							// Empty the set and restart the text
							phase_d  = prs_pkg::PH_START;
							acc_d    = '0;
							pend_d   = '0;
							seen_d   = '0;
							mark_d   = '0;
							halted_d = 1'b0;
							ovf_d    = 1'b0;
							req.clr  = 1'b1;
						end
						prs_pkg::OP_CHAR: begin
							if (!halted_q) begin
								seen_d  = seen_inc[16] ? prs_pkg::VAL_MAX : seen_inc[15:0];
								pos_d   = seen_q;
								comma_d = (ch == prs_pkg::CH_COMMA);
								case (phase_q)
									prs_pkg::PH_START: begin
										if (is_digit) begin
											acc_d   = {13'b0, dval};
											phase_d = prs_pkg::PH_LOW;
										end else if (ch == prs_pkg::CH_DASH) begin
											pend_d  = '0;
											acc_d   = '0;
											phase_d = prs_pkg::PH_DASH;
										end else begin
											halted_d = 1'b1;
										end
									end
									prs_pkg::PH_LOW: begin
										if (is_digit) begin
											acc_d = acc_next;
										end else if (acc_q[16]) begin
											halted_d = 1'b1;
										end else if (ch == prs_pkg::CH_DASH) begin
											pend_d  = acc_q[15:0];
											acc_d   = '0;
											phase_d = prs_pkg::PH_DASH;
										end else begin
											req.start = 1'b1;
											req.lo    = acc_q[15:0];
											req.hi    = acc_q[15:0];
											st_d      = prs_pkg::ST_WAIT;
										end
									end
									prs_pkg::PH_DASH: begin
										if (is_digit) begin
											acc_d   = {13'b0, dval};
											phase_d = prs_pkg::PH_HIGH;
										end else begin
											// Open high bound
											req.start = 1'b1;
											req.lo    = pend_q;
											req.hi    = prs_pkg::VAL_MAX;
											st_d      = prs_pkg::ST_WAIT;
										end
									end
									default: begin
										if (is_digit) begin
											acc_d = acc_next;
										end else if (acc_q[16] || acc_q[15:0] < pend_q) begin
											halted_d = 1'b1;
										end else begin
											req.start = 1'b1;
											req.lo    = pend_q;
											req.hi    = acc_q[15:0];
											st_d      = prs_pkg::ST_WAIT;
										end
									end
								endcase
							end
						end
						prs_pkg::OP_QUERY: begin
							match_d = tbl_hit;
						end
						default: begin
						end
					endcase
				end
			end
			prs_pkg::ST_WAIT: begin
				if (rsp.done) begin
					st_d = prs_pkg::ST_REPORT;
					if (!rsp.ok) begin
						ovf_d    = 1'b1;
						halted_d = 1'b1;
					end else begin
						acc_d = '0;
						if (comma_q) begin
							mark_d  = pos_inc[16] ? prs_pkg::VAL_MAX : pos_inc[15:0];
							phase_d = prs_pkg::PH_START;
						end else begin
							mark_d   = pos_q;
							halted_d = 1'b1;
						end
					end
				end
			end
			prs_pkg::ST_REPORT: begin
				st_d = prs_pkg::ST_IDLE;
			end
			default: begin
				st_d = prs_pkg::ST_IDLE;
			end
		endcase
	end

	// Result register: load on report, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == prs_pkg::ST_REPORT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == prs_pkg::ST_REPORT) begin
			out_data_q <= {7'b0, ovf_q, tbl_cov, prs_pkg::TOTAL_W'(tbl_cnt),
			               halted_q, mark_q, match_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* sim/prs_checker.sv */
// Checker for the port range set: watches both channels, predicts each result and compares.
module prs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	output int          fail_count,
	output int          pending_count,
	output int          result_count,
	output int          match_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        hit;
		logic [15:0] consumed;
		logic        stopped;
		logic [4:0]  total;
		logic [16:0] covered;
		logic        ovf;
	} status_t;

	status_t status_q[$];

	int unsigned     set_lo[prs_pkg::MAX_RANGES];
	int unsigned     set_hi[prs_pkg::MAX_RANGES];
	int unsigned     set_n;
	prs_pkg::phase_t phase;
	int unsigned     accum, low_pend, seen, mark;
	bit              halted, ovf;

	function automatic int unsigned sat16(int unsigned v);
		return (v > 65535) ? 65535 : v;
	endfunction

	function automatic void clear_set();
		set_n = 0; phase = prs_pkg::PH_START; accum = 0; low_pend = 0;
		seen = 0; mark = 0; halted = 0; ovf = 0;
	endfunction

	// Merge lo..hi into the sorted disjoint table; false when a new slot is needed but none is free.
	function automatic bit merge_range(int unsigned lo, int unsigned hi);
		int unsigned nl[prs_pkg::MAX_RANGES+1];
		int unsigned nh[prs_pkg::MAX_RANGES+1];
		int unsigned n;
		bit placed;
		n = 0;
		placed = 0;
		for (int i = 0; i < set_n; i++)
			if (set_hi[i] + 1 >= lo && set_lo[i] <= hi + 1) begin
				if (set_lo[i] < lo) lo = set_lo[i];
				if (set_hi[i] > hi) hi = set_hi[i];
			end
		for (int i = 0; i < set_n; i++) begin
			if (set_hi[i] + 1 >= lo && set_lo[i] <= hi + 1) continue;
			if (!placed && set_lo[i] > hi) begin
				nl[n] = lo; nh[n] = hi; n++; placed = 1;
			end
			nl[n] = set_lo[i]; nh[n] = set_hi[i]; n++;
		end
		if (!placed) begin
			nl[n] = lo; nh[n] = hi; n++;
		end
		if (n > prs_pkg::MAX_RANGES) return 0;
		for (int i = 0; i < n; i++) begin
			set_lo[i] = nl[i]; set_hi[i] = nh[i];
		end
		set_n = n;
		return 1;
	endfunction

	function automatic void close_item(int unsigned lo, int unsigned hi, logic [7:0] c,
	                                   int unsigned pos);
		if (!merge_range(lo, hi)) begin
			ovf = 1; halted = 1; return;
		end
		accum = 0;
		if (c == prs_pkg::CH_COMMA) begin
			mark = sat16(pos + 1); phase = prs_pkg::PH_START;
		end else begin
			mark = pos; halted = 1;
		end
	endfunction

	function automatic void parse_char(logic [7:0] c);
		int unsigned pos;
		bit digit;
		int unsigned d;
		pos = seen;
		digit = (c >= prs_pkg::CH_ZERO && c <= prs_pkg::CH_NINE);
		d = digit ? int'(c - prs_pkg::CH_ZERO) : 0;
		seen = sat16(seen + 1);
		case (phase)
			prs_pkg::PH_START: begin
				if (digit) begin
					accum = d; phase = prs_pkg::PH_LOW;
				end else if (c == prs_pkg::CH_DASH) begin
					low_pend = 0; accum = 0; phase = prs_pkg::PH_DASH;
				end else halted = 1;
			end
			prs_pkg::PH_LOW: begin
				if (digit) begin
					accum = accum * 10 + d;
					if (accum > 65536) accum = 65536;
				end else if (accum > 65535) halted = 1;
				else if (c == prs_pkg::CH_DASH) begin
					low_pend = accum; accum = 0; phase = prs_pkg::PH_DASH;
				end else close_item(accum, accum, c, pos);
			end
			prs_pkg::PH_DASH: begin
				if (digit) begin
					accum = d; phase = prs_pkg::PH_HIGH;
				end else close_item(low_pend, 65535, c, pos);
			end
			default: begin
				if (digit) begin
					accum = accum * 10 + d;
					if (accum > 65536) accum = 65536;
				end else if (accum > 65535 || accum < low_pend) halted = 1;
				else close_item(low_pend, accum, c, pos);
			end
		endcase
	endfunction

	function automatic status_t apply_transaction(prs_pkg::op_t op, logic [7:0] c,
	                                              logic [15:0] q);
		status_t r;
		int unsigned cov;
		r.hit = 0;
		cov = 0;
		case (op)
			prs_pkg::OP_CLEAR: clear_set();
			prs_pkg::OP_CHAR:  if (!halted) parse_char(c);
			prs_pkg::OP_QUERY: begin
				for (int i = 0; i < set_n; i++) begin
					if (q < set_lo[i]) break;
					if (q <= set_hi[i]) begin
						r.hit = 1; break;
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < set_n; i++) cov += set_hi[i] - set_lo[i] + 1;
		r.consumed = mark[15:0];
		r.stopped  = halted;
		r.total    = set_n[4:0];
		r.covered  = cov[16:0];
		r.ovf      = ovf;
		return r;
	endfunction

	initial clear_set();

	always @(posedge clk or negedge arst_n) begin
		status_t want, got;
		if (!arst_n) begin
			fail_count    <= 0;
			result_count  <= 0;
			match_hits    <= 0;
			pending_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				status_q.push_back(apply_transaction(prs_pkg::op_t'(s_tuser), s_tdata[7:0],
				                                     s_tdata[23:8]));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[16:1], m_tdata[17], m_tdata[22:18],
				       m_tdata[39:23], m_tdata[40]};
				result_count <= result_count + 1;
				if (status_q.size() == 0) begin
					$error("result with nothing expected: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = status_q.pop_front();
					if (want.hit) match_hits <= match_hits + 1;
					if (got != want || m_tdata[47:41] != 0) begin
						fail_count <= fail_count + 1;
						if (got.hit != want.hit)
							$error("match_found exp %0d got %0d", want.hit, got.hit);
						if (got.consumed != want.consumed)
							$error("chars_consumed exp %0d got %0d", want.consumed, got.consumed);
						if (got.stopped != want.stopped)
							$error("parse_stopped exp %0d got %0d", want.stopped, got.stopped);
						if (got.total != want.total)
							$error("range_total exp %0d got %0d", want.total, got.total);
						if (got.covered != want.covered)
							$error("covered_values exp %0d got %0d", want.covered, got.covered);
						if (got.ovf != want.ovf)
							$error("table_overflow exp %0d got %0d", want.ovf, got.ovf);
						if (m_tdata[47:41] != 0)
							$error("zero fill exp 0 got %h", m_tdata[47:41]);
					end
				end
			end
			pending_count <= status_q.size();
		end
	end
endmodule

/* sim/tb_port_range_set_parse_match.sv */
// Testbench top for the port range set: stimulus, handshake pacing and verdict.
module tb_port_range_set_parse_match;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = prs_pkg::OP_STATUS;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;

	int fail_count, pending_count, result_count, match_hits;
	int sent;
	bit steady;        // no idling on either side while set
	bit steady_done;
	bit hold_off;      // receiver long stall request
	bit pressure_done;
	byte unsigned txt[$];

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	port_range_set_parse_match u_dut (.*);

	prs_checker u_chk (.*);

	// Receiver: random stalls, none in steady stretches, one long hold when asked.
	always @(negedge clk) begin
		if (!arst_n) m_tready <= 0;
		else if (hold_off) m_tready <= 0;
		else m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 23);
	end

	// Present one transaction; hold it until the block takes it.
	task automatic send(prs_pkg::op_t op, logic [7:0] c, logic [15:0] q);
		if (!steady)
			while ($urandom_range(99) < 23) begin
				s_tvalid <= 0;
				@(negedge clk);
			end
		s_tvalid <= 1;
		s_tuser  <= op;
		s_tdata  <= {q, c};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send(prs_pkg::OP_CHAR, s[i], 16'($urandom));
	endtask

	// Append a random number up to lim; sometimes near or over the top.
	task automatic add_num(int unsigned lim);
		int unsigned v;
		string s;
		v = $urandom_range(lim);
		if ($urandom_range(9) == 0) v = $urandom_range(70000, 65530);
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
	endtask

	task automatic random_list();
		int items, lim;
		txt.delete();
		items = $urandom_range(22, 1);
		lim = ($urandom_range(1)) ? 200 : 65535;
		for (int k = 0; k < items; k++) begin
			case ($urandom_range(5))
				0, 1: add_num(lim);
				2: begin add_num(lim); txt.push_back("-"); add_num(lim); end
				3: begin add_num(lim); txt.push_back("-"); end
				4: begin txt.push_back("-"); add_num(lim); end
				default: if ($urandom_range(3) == 0) txt.push_back("-");
					else begin add_num(lim); txt.push_back("-"); add_num(lim); end
			endcase
			// occasional broken sequence
			if ($urandom_range(19) == 0) txt.push_back(8'($urandom_range(255)));
			if (k < items - 1) txt.push_back(",");
		end
		txt.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'h00);
		send(prs_pkg::OP_CLEAR, 8'($urandom), 16'($urandom));
		foreach (txt[i]) begin
			send(prs_pkg::OP_CHAR, txt[i], 16'($urandom));
			if ($urandom_range(7) == 0) send(prs_pkg::OP_QUERY, 8'($urandom), 16'($urandom));
		end
		repeat ($urandom_range(8, 2))
			send(prs_pkg::OP_QUERY, 8'($urandom),
			     $urandom_range(3) == 0 ? 16'($urandom_range(255)) : 16'($urandom));
		if ($urandom_range(9) == 0) send(prs_pkg::OP_STATUS, 8'($urandom), 16'($urandom));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes, every operation, each stop condition.
		send(prs_pkg::OP_STATUS, 8'hFF, 16'hFFFF);
		send_text("0,65535,-,");
		send(prs_pkg::OP_QUERY, 8'd0, 16'd0);
		send(prs_pkg::OP_QUERY, 8'd0, 16'hFFFF);
		send(prs_pkg::OP_CLEAR, 8'd0, 16'd0);
		send_text("80,443,1000-2000,2001-,x");   // adjacent merge, open high, bad char
		send(prs_pkg::OP_QUERY, 8'd0, 16'd1500);
		send(prs_pkg::OP_CLEAR, 8'd0, 16'd0);
		send_text("65536,");                     // value too big
		send(prs_pkg::OP_CLEAR, 8'd0, 16'd0);
		send_text("9-3,");                       // high below low
		send(prs_pkg::OP_CLEAR, 8'd0, 16'd0);
		send_text("5--");                        // second dash
		send(prs_pkg::OP_CLEAR, 8'd0, 16'd0);
		send_text(",");                          // empty item
		send(prs_pkg::OP_CLEAR, 8'd0, 16'd0);
		// full table: 17 separate values
		for (int i = 0; i < 17; i++) send_text($sformatf("%0d,", i * 3));
		send_text("1,");                          // merge into existing still fits? stopped already
		send(prs_pkg::OP_QUERY, 8'd0, 16'd48);

		// Random lists; a steady stretch and one long receiver hold-off on the way.
		while (sent < 1970) begin
			if (steady && sent > 800) begin
				steady = 0;
				steady_done = 1;
			end else if (!steady_done && sent > 600) begin
				steady = 1;
			end
			random_list();
			if (sent > 1000 && !pressure_done) begin
				pressure_done = 1;
				hold_off = 1;
				fork
					begin
						repeat (300) @(negedge clk);
						hold_off = 0;
					end
				join_none
				send(prs_pkg::OP_QUERY, 8'd0, 16'($urandom));
				send(prs_pkg::OP_QUERY, 8'd0, 16'($urandom));
				send(prs_pkg::OP_STATUS, 8'd0, 16'd0);
			end
		end
		s_tvalid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d transactions, %0d results, %0d query hits", sent, result_count,
		         match_hits);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
